// ===== hdl/alle_pkg.sv =====
`default_nettype none

package alle_pkg;

	localparam int unsigned DEPTH = 256;
	localparam int unsigned IDX_W = 8;
	localparam int unsigned CNT_W = 9;
	localparam int unsigned VAL_W = 64;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [VAL_W-1:0] val_t;

	typedef enum logic [2:0] {
		FN_REWIND  = 3'd0,
		FN_ADVANCE = 3'd1,
		FN_READ    = 3'd2,
		FN_WRITE   = 3'd3,
		FN_INSERT  = 3'd4,
		FN_REMOVE  = 3'd5,
		FN_APPEND  = 3'd6
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ===== hdl/array_linked_list_engine_top.sv =====
`default_nettype none

// Circular singly linked list of 64-bit values held in three on-chip memories
// (values, next links, free-slot stack) with one cursor and its predecessor.
// Each accepted word runs one function (rewind, advance, read, write, insert
// after, remove, append) and returns one result word: the value at the cursor,
// the cursor slot, the free count and a status. A new word is not taken while
// the last one is still in its second stage; the link memory sets this, as its
// read of the cursor's successor must land before links are written back. A
// result passes the second stage, the third stage and the output register, and
// out_stall can hold it back. Writing entries_in_use (0 reads as 1, above 256 as
// 256) reinitializes the list: the free stack starts from a low-water mark, so
// there is no clearing pass. Write entries_in_use only while no word is in flight.
module array_linked_list_engine_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [8:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  func,
	input  wire logic [63:0] write_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      read_value,
	output logic [7:0]       cursor_index,
	output logic [8:0]       free_entries,
	output logic [1:0]       status
);

	logic accept, s2_adv, s3_adv;
	logic valid_s2, valid_s3, out_valid_q;

	alle_pkg::cnt_t n_q, fc_q, lw_q, fc_d, lw_d, cfg_n, pop_pos, init_top;
	alle_pkg::idx_t head_q, tail_q, cur_q, prev_q;
	alle_pkg::idx_t head_d, tail_d, cur_d, prev_d, top;
	alle_pkg::status_t status_d;
	logic empty, full, empty_d;

	logic [2:0]     func_s2;
	alle_pkg::val_t wv_s2;

	alle_pkg::val_t val_mem [alle_pkg::DEPTH];
	alle_pkg::idx_t lnk_mem [alle_pkg::DEPTH];
	alle_pkg::idx_t fs_mem  [alle_pkg::DEPTH];

	alle_pkg::idx_t lk_rd_s2, fs_rd_s2;
	alle_pkg::val_t vl_rd_s3;

	logic           lk1_we, lk2_we, lk_we;
	alle_pkg::idx_t lk1_wa, lk1_wd, lk2_wa, lk2_wd, lk_wa, lk_wd;
	logic           lk2_v_q;
	alle_pkg::idx_t lk2_wa_q, lk2_wd_q;
	logic           vl_we;
	alle_pkg::idx_t vl_wa;
	logic           fs_we;

	alle_pkg::idx_t    cur_s3;
	alle_pkg::cnt_t    fc_s3;
	alle_pkg::status_t status_s3;
	logic              empty_s3;

	alle_pkg::val_t    read_value_q;
	alle_pkg::idx_t    cursor_q;
	alle_pkg::cnt_t    free_q;
	alle_pkg::status_t status_q;

	assign in_stall = valid_s2;
	assign accept   = in_valid && !valid_s2;
	assign s3_adv   = valid_s3 && (!out_valid_q || !out_stall);
	assign s2_adv   = valid_s2 && (!valid_s3 || s3_adv);

	always_comb begin
		if (cfg_wr_data == '0) begin
			cfg_n = alle_pkg::CNT_W'(1);
		end else if (cfg_wr_data > alle_pkg::CNT_W'(alle_pkg::DEPTH)) begin
			cfg_n = alle_pkg::CNT_W'(alle_pkg::DEPTH);
		end else begin
			cfg_n = cfg_wr_data;
		end
	end

	// top of free stack; positions below the low-water mark still hold their initial slot
	assign pop_pos  = fc_q - alle_pkg::CNT_W'(1);
	assign init_top = n_q - fc_q;
	assign top      = (fc_q == lw_q) ? init_top[alle_pkg::IDX_W-1:0] : fs_rd_s2;
	assign empty    = fc_q >= n_q;
	assign full     = fc_q == '0;

	always_comb begin
		cur_d    = cur_q;
		prev_d   = prev_q;
		head_d   = head_q;
		tail_d   = tail_q;
		fc_d     = fc_q;
		lw_d     = lw_q;
		status_d = alle_pkg::ST_OK;
		lk1_we   = 1'b0;
		lk1_wa   = cur_q;
		lk1_wd   = top;
		lk2_we   = 1'b0;
		lk2_wa   = cur_q;
		lk2_wd   = top;
		vl_we    = 1'b0;
		vl_wa    = cur_q;
		fs_we    = 1'b0;
		if (func_s2 == alle_pkg::FN_APPEND) begin
			if (full) begin
				status_d = alle_pkg::ST_FULL;
			end else begin
				fc_d  = pop_pos;
				lw_d  = (fc_q == lw_q) ? pop_pos : lw_q;
				vl_we = 1'b1;
				vl_wa = top;
				if (empty) begin
					head_d = top;
					tail_d = top;
					cur_d  = top;
					prev_d = top;
					lk1_we = 1'b1;
					lk1_wa = top;
					lk1_wd = top;
				end else begin
					lk1_we = 1'b1;
					lk1_wa = tail_q;
					lk1_wd = top;
					lk2_we = 1'b1;
					lk2_wa = top;
					lk2_wd = head_q;
					tail_d = top;
					if (cur_q == head_q) begin
						prev_d = top;
					end
				end
			end
		end else if (empty) begin
			status_d = alle_pkg::ST_EMPTY;
		end else begin
			case (func_s2)
				alle_pkg::FN_REWIND: begin
					cur_d  = head_q;
					prev_d = tail_q;
				end
				alle_pkg::FN_ADVANCE: begin
					prev_d = cur_q;
					cur_d  = lk_rd_s2;
				end
				alle_pkg::FN_WRITE: begin
					vl_we = 1'b1;
					vl_wa = cur_q;
				end
				alle_pkg::FN_INSERT: begin
					if (full) begin
						status_d = alle_pkg::ST_FULL;
					end else begin
						fc_d   = pop_pos;
						lw_d   = (fc_q == lw_q) ? pop_pos : lw_q;
						vl_we  = 1'b1;
						vl_wa  = top;
						lk1_we = 1'b1;
						lk1_wa = top;
						lk1_wd = lk_rd_s2;
						lk2_we = 1'b1;
						lk2_wa = cur_q;
						lk2_wd = top;
						if (cur_q == tail_q) begin
							tail_d = top;
						end
					end
				end
				alle_pkg::FN_REMOVE: begin
					fs_we = 1'b1;
					fc_d  = fc_q + alle_pkg::CNT_W'(1);
					if (fc_d < n_q) begin
						lk1_we = 1'b1;
						lk1_wa = prev_q;
						lk1_wd = lk_rd_s2;
						if (cur_q == head_q) begin
							head_d = lk_rd_s2;
						end
						if (cur_q == tail_q) begin
							tail_d = prev_q;
						end
						cur_d = lk_rd_s2;
					end
				end
				default: begin
				end
			endcase
		end
		empty_d = fc_d >= n_q;
	end

	// second link write of insert/append lands in the cycle after commit
	assign lk_we = (s2_adv && lk1_we) || lk2_v_q;
	assign lk_wa = (s2_adv && lk1_we) ? lk1_wa : lk2_wa_q;
	assign lk_wd = (s2_adv && lk1_we) ? lk1_wd : lk2_wd_q;

	always_ff @(posedge clk) begin
		if (lk_we) begin
			lnk_mem[lk_wa] <= lk_wd;
		end
		if (accept) begin
			lk_rd_s2 <= (lk_we && lk_wa == cur_q) ? lk_wd : lnk_mem[cur_q];
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && fs_we) begin
			fs_mem[fc_q[alle_pkg::IDX_W-1:0]] <= cur_q;
		end
		if (accept) begin
			fs_rd_s2 <= fs_mem[pop_pos[alle_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && vl_we) begin
			val_mem[vl_wa] <= wv_s2;
		end
		if (s2_adv) begin
			vl_rd_s3 <= (vl_we && vl_wa == cur_d) ? wv_s2 : val_mem[cur_d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			lk2_v_q     <= 1'b0;
			n_q         <= alle_pkg::CNT_W'(alle_pkg::DEPTH);
			fc_q        <= alle_pkg::CNT_W'(alle_pkg::DEPTH);
			lw_q        <= alle_pkg::CNT_W'(alle_pkg::DEPTH);
			head_q      <= '0;
			tail_q      <= '0;
			cur_q       <= '0;
			prev_q      <= '0;
		end else begin
			valid_s2    <= accept || (valid_s2 && !s2_adv);
			valid_s3    <= s2_adv || (valid_s3 && !s3_adv);
			out_valid_q <= s3_adv || (out_valid_q && out_stall);
			lk2_v_q     <= s2_adv && lk2_we;
			if (cfg_wr_en) begin
				n_q    <= cfg_n;
				fc_q   <= cfg_n;
				lw_q   <= cfg_n;
				head_q <= '0;
				tail_q <= '0;
				cur_q  <= '0;
				prev_q <= '0;
			end else if (s2_adv) begin
				fc_q   <= fc_d;
				lw_q   <= lw_d;
				head_q <= head_d;
				tail_q <= tail_d;
				cur_q  <= cur_d;
				prev_q <= prev_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s2 <= func;
			wv_s2   <= write_value;
		end
		if (s2_adv) begin
			cur_s3    <= cur_d;
			fc_s3     <= fc_d;
			status_s3 <= status_d;
			empty_s3  <= empty_d;
			lk2_wa_q  <= lk2_wa;
			lk2_wd_q  <= lk2_wd;
		end
		if (s3_adv) begin
			read_value_q <= empty_s3 ? '0 : vl_rd_s3;
			cursor_q     <= cur_s3;
			free_q       <= fc_s3;
			status_q     <= status_s3;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_value   = read_value_q;
	assign cursor_index = cursor_q;
	assign free_entries = free_q;
	assign status       = status_q;

endmodule

`default_nettype wire

// ===== hdl/alle_chk.sv =====
`default_nettype none

module alle_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [63:0] read_value,
	input wire logic [7:0]  cursor_index,
	input wire logic [8:0]  free_entries,
	input wire logic [1:0]  status
);

	a_full_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == alle_pkg::ST_FULL |-> free_entries == '0)
		else $error("full status with free slots left");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == alle_pkg::ST_EMPTY |-> read_value == '0)
		else $error("empty status with nonzero read value");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> free_entries <= 9'(alle_pkg::DEPTH))
		else $error("free count above depth");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken while first still in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(cursor_index))
		else $error("stalled result word changed");

endmodule

bind array_linked_list_engine_top alle_chk u_alle_chk (.*);

`default_nettype wire
